// ===== hdl/bezier_point_and_tangent_eval_unit_defines.svh =====
// ----------------------------------------------------------------------------
// bezier point and tangent evaluator assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef BEZIER_POINT_AND_TANGENT_EVAL_UNIT_DEFINES_SVH
`define BEZIER_POINT_AND_TANGENT_EVAL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property checked out of reset
`define BPTE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bpte assertion failed");
// property checked during reset as well
`define BPTE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("bpte assertion failed");
`else
`define BPTE_ASSERT(lbl, prop)
`define BPTE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/bpte_pkg.sv =====
// ----------------------------------------------------------------------------
// bpte_pkg
// shared widths and types of the bezier evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpte_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int T_W        = 18;
    localparam int TU_W       = FRAC_BITS + 1;
    localparam int CNT_W      = 5;
    localparam int OUT_W      = 48;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + TU_W + 1;
    localparam int SHIFT_W    = PROD_W - FRAC_BITS;
    localparam int DERIV_W    = DIFF_W + IDX_W + 1;
    localparam int PAIR_W     = 2 * COORD_W;

    // operation codes of an input transaction
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // per-step control carried down the interpolation pipeline
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             src_ctrl;
        logic             last;
        logic             deriv;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/bpte_ram.sv =====
// ----------------------------------------------------------------------------
// bpte_ram
// one write port, two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpte_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bpte_lerp.sv =====
// ----------------------------------------------------------------------------
// bpte_lerp
// fixed point interpolation a + round((b - a) * t), both lanes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpte_lerp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [bpte_pkg::IDX_W-1:0]        degree,
    input  wire logic [bpte_pkg::TU_W-1:0]         t,
    input  wire logic                              in_valid,
    input  wire bpte_pkg::pipe_ctrl_t              in_ctrl,
    input  wire logic signed [bpte_pkg::COORD_W-1:0] ax,
    input  wire logic signed [bpte_pkg::COORD_W-1:0] bx,
    input  wire logic signed [bpte_pkg::COORD_W-1:0] ay,
    input  wire logic signed [bpte_pkg::COORD_W-1:0] by,
    output logic                                   busy,
    output logic                                   out_valid,
    output bpte_pkg::pipe_ctrl_t                   out_ctrl,
    output logic signed [bpte_pkg::COORD_W-1:0]    res_x,
    output logic signed [bpte_pkg::COORD_W-1:0]    res_y,
    output logic signed [bpte_pkg::DERIV_W-1:0]    deriv_x,
    output logic signed [bpte_pkg::DERIV_W-1:0]    deriv_y
);

    localparam logic signed [bpte_pkg::PROD_W-1:0] ROUND_HALF =
        bpte_pkg::PROD_W'(1) <<< (bpte_pkg::FRAC_BITS - 1);

    logic                                  v2_reg;
    bpte_pkg::pipe_ctrl_t                  p2_reg;
    logic signed [bpte_pkg::DIFF_W-1:0]    dx2_reg, dy2_reg;
    logic signed [bpte_pkg::COORD_W-1:0]   ax2_reg, ay2_reg;
    logic                                  v3_reg;
    bpte_pkg::pipe_ctrl_t                  p3_reg;
    logic signed [bpte_pkg::PROD_W-1:0]    px3_reg, py3_reg;
    logic signed [bpte_pkg::COORD_W-1:0]   ax3_reg, ay3_reg;
    logic signed [bpte_pkg::DERIV_W-1:0]   dvx_reg, dvy_reg;
    logic signed [bpte_pkg::TU_W:0]        t_s;
    logic signed [bpte_pkg::IDX_W:0]       n_s;
    logic signed [bpte_pkg::SHIFT_W-1:0]   sx, sy;
    logic signed [bpte_pkg::SHIFT_W-1:0]   sum_x, sum_y;

    function automatic logic signed [bpte_pkg::DIFF_W-1:0] DIFF_W_SUB(
        input logic signed [bpte_pkg::COORD_W-1:0] b,
        input logic signed [bpte_pkg::COORD_W-1:0] a
    );
        DIFF_W_SUB = bpte_pkg::DIFF_W'(b) - bpte_pkg::DIFF_W'(a);
    endfunction

    assign t_s = $signed({1'b0, t});
    assign n_s = $signed({1'b0, degree});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
        end
    end

    // difference stage
    always_ff @(posedge aclk) begin
        p2_reg  <= in_ctrl;
        dx2_reg <= DIFF_W_SUB(bx, ax);
        dy2_reg <= DIFF_W_SUB(by, ay);
        ax2_reg <= ax;
        ay2_reg <= ay;
    end

    // product stage, rounding offset folded in
    always_ff @(posedge aclk) begin
        p3_reg  <= p2_reg;
        px3_reg <= bpte_pkg::PROD_W'(dx2_reg * t_s) + ROUND_HALF;
        py3_reg <= bpte_pkg::PROD_W'(dy2_reg * t_s) + ROUND_HALF;
        ax3_reg <= ax2_reg;
        ay3_reg <= ay2_reg;
    end

    // derivative n * (b1 - b0) from the next to last level
    always_ff @(posedge aclk) begin
        if (start) begin
            dvx_reg <= '0;
            dvy_reg <= '0;
        end else if (v2_reg && p2_reg.deriv) begin
            dvx_reg <= bpte_pkg::DERIV_W'(dx2_reg * n_s);
            dvy_reg <= bpte_pkg::DERIV_W'(dy2_reg * n_s);
        end
    end

    assign sx    = bpte_pkg::SHIFT_W'(px3_reg >>> bpte_pkg::FRAC_BITS);
    assign sy    = bpte_pkg::SHIFT_W'(py3_reg >>> bpte_pkg::FRAC_BITS);
    assign sum_x = bpte_pkg::SHIFT_W'(ax3_reg) + sx;
    assign sum_y = bpte_pkg::SHIFT_W'(ay3_reg) + sy;

    assign res_x     = sum_x[bpte_pkg::COORD_W-1:0];
    assign res_y     = sum_y[bpte_pkg::COORD_W-1:0];
    assign out_valid = v3_reg;
    assign out_ctrl  = p3_reg;
    assign busy      = v2_reg | v3_reg;
    assign deriv_x   = dvx_reg;
    assign deriv_y   = dvy_reg;

endmodule

`default_nettype wire

// ===== hdl/bezier_point_and_tangent_eval_unit.sv =====
// operation: a load writes its point on acceptance; an evaluate runs level by level,
//   issuing the reads of a level and then draining until its writes have landed
// throughput: one evaluate at a time, the next transaction taken only once its result is
//   registered in the output register; a load leaves the block idle for the next one
// reset: aresetn synchronous active low clears control, point_count returns to 1;
//   the point stores are not cleared
// ----------------------------------------------------------------------------
// bezier_point_and_tangent_eval_unit
// bezier curve point and first derivative evaluation over stored control points
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bezier_point_and_tangent_eval_unit_defines.svh"

module bezier_point_and_tangent_eval_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [bpte_pkg::CNT_W-1:0]          cfg_wdata,
    // input transactions
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_operation,
    input  wire logic [bpte_pkg::IDX_W-1:0]          s_point_index,
    input  wire logic signed [bpte_pkg::COORD_W-1:0] s_point_x,
    input  wire logic signed [bpte_pkg::COORD_W-1:0] s_point_y,
    input  wire logic signed [bpte_pkg::T_W-1:0]     s_param_t,
    // result transactions
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [bpte_pkg::OUT_W-1:0]        m_curve_x,
    output logic signed [bpte_pkg::OUT_W-1:0]        m_curve_y,
    output logic signed [bpte_pkg::OUT_W-1:0]        m_deriv_x,
    output logic signed [bpte_pkg::OUT_W-1:0]        m_deriv_y,
    output logic                                     m_status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    localparam logic signed [bpte_pkg::T_W-1:0] T_ONE =
        bpte_pkg::T_W'(1) <<< bpte_pkg::FRAC_BITS;
    localparam logic [bpte_pkg::CNT_W-1:0] CNT_MAX = bpte_pkg::CNT_W'(bpte_pkg::MAX_POINTS);

    state_t                                state_reg, state_next;
    logic [bpte_pkg::CNT_W-1:0]            point_count_reg;
    logic [bpte_pkg::IDX_W-1:0]            n_reg, lim_reg, i_reg;
    logic                                  first_reg;
    logic [bpte_pkg::TU_W-1:0]             t_reg;
    logic                                  err_reg;
    logic                                  v1_reg;
    bpte_pkg::pipe_ctrl_t                  p1_reg;
    logic signed [bpte_pkg::COORD_W-1:0]   curve_x_reg, curve_y_reg;

    logic                                  m_valid_reg;
    logic signed [bpte_pkg::OUT_W-1:0]     m_curve_x_reg, m_curve_y_reg;
    logic signed [bpte_pkg::OUT_W-1:0]     m_deriv_x_reg, m_deriv_y_reg;
    logic                                  m_status_reg;

    logic                                  s_fire, load_fire, eval_fire;
    logic                                  t_bad;
    logic [bpte_pkg::IDX_W-1:0]            n_in;
    logic                                  rd_en;
    logic [bpte_pkg::IDX_W-1:0]            raddr_b;
    bpte_pkg::pipe_ctrl_t                  p0;
    logic [bpte_pkg::PAIR_W-1:0]           ctrl_a, ctrl_b, work_a, work_b;
    logic [bpte_pkg::PAIR_W-1:0]           sel_a, sel_b;
    logic                                  lerp_busy, lerp_valid;
    bpte_pkg::pipe_ctrl_t                  lerp_ctrl;
    logic signed [bpte_pkg::COORD_W-1:0]   res_x, res_y;
    logic signed [bpte_pkg::DERIV_W-1:0]   dv_x, dv_y;
    logic                                  out_free;

    // input handshake, one transaction at a time
    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid & s_ready;
    assign load_fire = s_fire & (s_operation == bpte_pkg::OP_LOAD);
    assign eval_fire = s_fire & (s_operation == bpte_pkg::OP_EVAL);

    // t must lie in [0, 1]
    assign t_bad = s_param_t[bpte_pkg::T_W-1] | (s_param_t > T_ONE);

    // degree from the count, zero read as one and large counts clamped
    always_comb begin
        if (point_count_reg == '0) begin
            n_in = '0;
        end else if (point_count_reg > CNT_MAX) begin
            n_in = bpte_pkg::IDX_W'(bpte_pkg::MAX_POINTS - 1);
        end else begin
            n_in = bpte_pkg::IDX_W'(point_count_reg - 1'b1);
        end
    end

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= bpte_pkg::CNT_W'(1);
        end else if (cfg_we) begin
            point_count_reg <= cfg_wdata;
        end
    end

    // read issue: step i of a level reads entries i and i+1, or entry 0 twice for a single point
    assign rd_en   = (state_reg == S_RUN);
    assign raddr_b = (n_reg == '0) ? '0 : i_reg + 1'b1;

    always_comb begin
        p0.idx      = i_reg;
        p0.src_ctrl = first_reg;
        p0.last     = (lim_reg == '0);
        p0.deriv    = (lim_reg == '0) && (n_reg != '0);
    end

    bpte_ram #(
        .DEPTH (bpte_pkg::MAX_POINTS),
        .WIDTH (bpte_pkg::PAIR_W)
    ) u_ctrl_ram (
        .aclk    (aclk),
        .we      (load_fire),
        .waddr   (s_point_index),
        .wdata   ({s_point_y, s_point_x}),
        .rd_en   (rd_en),
        .raddr_a (i_reg),
        .raddr_b (raddr_b),
        .rdata_a (ctrl_a),
        .rdata_b (ctrl_b)
    );

    // scratch triangle, updated in place level by level
    bpte_ram #(
        .DEPTH (bpte_pkg::MAX_POINTS),
        .WIDTH (bpte_pkg::PAIR_W)
    ) u_work_ram (
        .aclk    (aclk),
        .we      (lerp_valid),
        .waddr   (lerp_ctrl.idx),
        .wdata   ({res_y, res_x}),
        .rd_en   (rd_en),
        .raddr_a (i_reg),
        .raddr_b (raddr_b),
        .rdata_a (work_a),
        .rdata_b (work_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg <= p0;
    end

    // first level reads the control points, later levels the scratch copy
    assign sel_a = p1_reg.src_ctrl ? ctrl_a : work_a;
    assign sel_b = p1_reg.src_ctrl ? ctrl_b : work_b;

    bpte_lerp u_lerp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eval_fire),
        .degree    (n_reg),
        .t         (t_reg),
        .in_valid  (v1_reg),
        .in_ctrl   (p1_reg),
        .ax        (sel_a[bpte_pkg::COORD_W-1:0]),
        .bx        (sel_b[bpte_pkg::COORD_W-1:0]),
        .ay        (sel_a[bpte_pkg::PAIR_W-1:bpte_pkg::COORD_W]),
        .by        (sel_b[bpte_pkg::PAIR_W-1:bpte_pkg::COORD_W]),
        .busy      (lerp_busy),
        .out_valid (lerp_valid),
        .out_ctrl  (lerp_ctrl),
        .res_x     (res_x),
        .res_y     (res_y),
        .deriv_x   (dv_x),
        .deriv_y   (dv_y)
    );

    // curve point is the single write of the last level
    always_ff @(posedge aclk) begin
        if (lerp_valid && lerp_ctrl.last) begin
            curve_x_reg <= res_x;
            curve_y_reg <= res_y;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (eval_fire) begin
                    state_next = t_bad ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (i_reg == lim_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait for the level to land before the next reads
                if (!v1_reg && !lerp_busy) begin
                    state_next = (lim_reg == '0) ? S_DONE : S_RUN;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg     <= '0;
            lim_reg   <= '0;
            n_reg     <= '0;
            first_reg <= 1'b0;
            err_reg   <= 1'b0;
            t_reg     <= '0;
        end else begin
            if (eval_fire) begin
                n_reg     <= n_in;
                lim_reg   <= (n_in == '0) ? '0 : n_in - 1'b1;
                i_reg     <= '0;
                first_reg <= 1'b1;
                err_reg   <= t_bad;
                // a lone point passes through with zero weight on b
                t_reg     <= (n_in == '0) ? '0 : s_param_t[bpte_pkg::TU_W-1:0];
            end else if (state_reg == S_RUN) begin
                if (i_reg != lim_reg) begin
                    i_reg <= i_reg + 1'b1;
                end
            end else if ((state_reg == S_DRAIN) && (state_next == S_RUN)) begin
                lim_reg   <= lim_reg - 1'b1;
                i_reg     <= '0;
                first_reg <= 1'b0;
            end
        end
    end

    // output register, filled from done when free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            m_status_reg <= err_reg;
            if (err_reg) begin
                m_curve_x_reg <= '0;
                m_curve_y_reg <= '0;
                m_deriv_x_reg <= '0;
                m_deriv_y_reg <= '0;
            end else begin
                // all values fit the output range, sign extension only
                m_curve_x_reg <= bpte_pkg::OUT_W'(curve_x_reg);
                m_curve_y_reg <= bpte_pkg::OUT_W'(curve_y_reg);
                m_deriv_x_reg <= bpte_pkg::OUT_W'(dv_x);
                m_deriv_y_reg <= bpte_pkg::OUT_W'(dv_y);
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_curve_x = m_curve_x_reg;
    assign m_curve_y = m_curve_y_reg;
    assign m_deriv_x = m_deriv_x_reg;
    assign m_deriv_y = m_deriv_y_reg;
    assign m_status  = m_status_reg;

    // nothing in flight while new transactions are taken
    `BPTE_ASSERT(a_idle_quiet, s_ready |-> (!v1_reg && !lerp_busy))
    // reads never pass the end of the current level
    `BPTE_ASSERT(a_read_bound, rd_en |-> (i_reg <= lim_reg))
    // an error result carries zero curve x and derivative y fields
    `BPTE_ASSERT(a_err_zero, (m_valid && m_status) |-> (m_curve_x == '0 && m_deriv_y == '0))
    // the last level write lands while draining
    `BPTE_ASSERT(a_last_drain, (lerp_valid && lerp_ctrl.last) |-> (state_reg == S_DRAIN))

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bezier point and tangent evaluator: loads
// control points, sweeps point counts and curve parameters, and predicts
// every curve point, derivative and status from its own de casteljau model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import bpte_pkg::*;

    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_RANGE = 1'b1;
    localparam longint T_ONE    = longint'(1) << FRAC_BITS;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int NUM_PHASES   = 9;
    localparam int PHASE_ITEMS  = 195;

    // one expected result transaction
    typedef struct {
        logic [OUT_W-1:0] cx;
        logic [OUT_W-1:0] cy;
        logic [OUT_W-1:0] dx;
        logic [OUT_W-1:0] dy;
        logic             st;
    } curve_result_t;

    // ------------------------------------------------------------------------
    // predictor and expected result store
    // ------------------------------------------------------------------------
    class curve_scoreboard;
        logic [CNT_W-1:0] point_count;
        longint           px [MAX_POINTS];
        longint           py [MAX_POINTS];
        curve_result_t    pending [$];
        int               errors;
        int               matched;

        function void set_count(logic [CNT_W-1:0] v);
            point_count = v;
        endfunction

        // a + round((b - a) * t / 2^frac), rounding half up
        function longint interp(longint a, longint b, longint t);
            longint d, dh, dl, fr;
            d  = b - a;
            dh = d >>> FRAC_BITS;
            dl = d - (dh <<< FRAC_BITS);
            fr = (dl * t + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            return a + dh * t + fr;
        endfunction

        function logic [OUT_W-1:0] clamp(longint v);
            longint hi, lo;
            hi = (longint'(1) <<< (OUT_W - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v[OUT_W-1:0];
        endfunction

        function void note_input(logic op, logic [IDX_W-1:0] idx, logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y, logic signed [T_W-1:0] t);
            longint bx [MAX_POINTS];
            longint by [MAX_POINTS];
            longint tv, ddx, ddy;
            int eff, n;
            curve_result_t res;
            if (op == OP_LOAD) begin
                px[idx] = longint'(x);
                py[idx] = longint'(y);
                return;
            end
            tv = longint'(t);
            if (tv < 0 || tv > T_ONE) begin
                res = '{0, 0, 0, 0, STAT_RANGE};
                pending.push_back(res);
                return;
            end
            eff = point_count;
            if (eff == 0) eff = 1;
            if (eff > MAX_POINTS) eff = MAX_POINTS;
            n = eff - 1;
            ddx = 0;
            ddy = 0;
            for (int i = 0; i < eff; i++) begin
                bx[i] = px[i];
                by[i] = py[i];
            end
            for (int r = 1; r <= n; r++) begin
                if (r == n) begin
                    ddx = n * (bx[1] - bx[0]);
                    ddy = n * (by[1] - by[0]);
                end
                for (int i = 0; i + r <= n; i++) begin
                    bx[i] = interp(bx[i], bx[i+1], tv);
                    by[i] = interp(by[i], by[i+1], tv);
                end
            end
            res = '{clamp(bx[0]), clamp(by[0]), clamp(ddx), clamp(ddy), STAT_OK};
            pending.push_back(res);
        endfunction

        function void check_result(logic [OUT_W-1:0] cx, logic [OUT_W-1:0] cy,
                                   logic [OUT_W-1:0] dx, logic [OUT_W-1:0] dy, logic st);
            curve_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transaction", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (cx !== e.cx) begin
                $display("%0t: curve_x expected %h got %h", $time, e.cx, cx);
                errors++;
            end
            if (cy !== e.cy) begin
                $display("%0t: curve_y expected %h got %h", $time, e.cy, cy);
                errors++;
            end
            if (dx !== e.dx) begin
                $display("%0t: deriv_x expected %h got %h", $time, e.dx, dx);
                errors++;
            end
            if (dy !== e.dy) begin
                $display("%0t: deriv_y expected %h got %h", $time, e.dy, dy);
                errors++;
            end
            if (st !== e.st) begin
                $display("%0t: status expected %b got %b", $time, e.st, st);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CNT_W-1:0]          cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_operation;
    logic [IDX_W-1:0]          s_point_index;
    logic signed [COORD_W-1:0] s_point_x;
    logic signed [COORD_W-1:0] s_point_y;
    logic signed [T_W-1:0]     s_param_t;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [OUT_W-1:0]   m_curve_x;
    logic signed [OUT_W-1:0]   m_curve_y;
    logic signed [OUT_W-1:0]   m_deriv_x;
    logic signed [OUT_W-1:0]   m_deriv_y;
    logic                      m_status;

    curve_scoreboard sb;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    int  cycle_count = 0;
    int  load_count;
    int  eval_count;
    logic hold_toggle;
    logic hold_seen = 1'b0;
    int  hold_left = 0;

    bezier_point_and_tangent_eval_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_point_index (s_point_index),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_param_t     (s_param_t),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_curve_x     (m_curve_x),
        .m_curve_y     (m_curve_y),
        .m_deriv_x     (m_deriv_x),
        .m_deriv_y     (m_deriv_y),
        .m_status      (m_status)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // result checking at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_curve_x, m_curve_y, m_deriv_x, m_deriv_y, m_status);
    end

    // offer one input transaction and wait for it to be taken
    task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic signed [T_W-1:0] t);
        @(negedge aclk);
        // sender gaps, valid low while idling
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_point_index <= idx;
        s_point_x     <= x;
        s_point_y     <= y;
        s_param_t     <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(op, idx, x, y, t);
        if (op == OP_EVAL) eval_count++;
        else load_count++;
    endtask

    task automatic load_point(logic [IDX_W-1:0] idx, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y);
        send_item(OP_LOAD, idx, x, y, T_W'($urandom()));
    endtask

    task automatic eval_at(logic signed [T_W-1:0] t);
        send_item(OP_EVAL, IDX_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()), t);
    endtask

    // wait out all pending results and the block's tail, then write the count
    task automatic write_count(logic [CNT_W-1:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (220) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        sb.set_count(v);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // coordinate with a bias toward the extremes
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0: return {1'b0, {(COORD_W-1){1'b1}}};
            1: return {1'b1, {(COORD_W-1){1'b0}}};
            2: return COORD_W'($urandom_range(255) - 128);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // parameter: mostly inside zero to one, sometimes outside
    function automatic logic signed [T_W-1:0] pick_param();
        case ($urandom_range(19))
            0: return '0;
            1: return T_W'(T_ONE);
            2: return T_W'(-$signed({1'b0, T_W'($urandom_range(131072, 1))}));
            3: return T_W'(T_ONE + 1 + $urandom_range(131071 - T_ONE - 1));
            default: return T_W'($urandom_range(T_ONE));
        endcase
    endfunction

    // random count, mostly small sizes, rarely the largest or out of range
    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(7))
            0: return CNT_W'($urandom_range(31));
            1: return CNT_W'(MAX_POINTS);
            default: return CNT_W'($urandom_range(6));
        endcase
    endfunction

    initial begin
        logic [CNT_W-1:0] counts [NUM_PHASES];
        logic signed [T_W-1:0] edge_params [9];
        sb = new();
        sb.set_count(1);
        sb.errors  = 0;
        sb.matched = 0;
        load_count    = 0;
        eval_count    = 0;
        hold_toggle   = 1'b0;
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_operation   = OP_LOAD;
        s_point_index = '0;
        s_point_x     = '0;
        s_point_y     = '0;
        s_param_t     = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part: fill every store entry first, so nothing unwritten is read
        for (int i = 0; i < MAX_POINTS; i++)
            load_point(IDX_W'(i),
                       (i % 2) ? {1'b0, {(COORD_W-1){1'b1}}} : {1'b1, {(COORD_W-1){1'b0}}},
                       (i % 3) ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}});
        // single point at reset count
        eval_at(T_W'(T_ONE / 2));
        write_count(CNT_W'(MAX_POINTS));
        edge_params = '{T_W'(0), T_W'(T_ONE), T_W'(T_ONE / 2), T_W'(1), T_W'(T_ONE - 1),
                        T_W'(-1), T_W'(T_ONE + 1),
                        {1'b1, {(T_W-1){1'b0}}}, {1'b0, {(T_W-1){1'b1}}}};
        foreach (edge_params[k]) eval_at(edge_params[k]);

        // random part: a point count per phase, an idling mix per group of three
        counts = '{CNT_W'(0), CNT_W'(2), CNT_W'(3), CNT_W'(17), CNT_W'(31), CNT_W'(4),
                   CNT_W'(1), pick_count(), pick_count()};
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_count(counts[ph]);
            case (ph * 3 / NUM_PHASES)
                0: begin snd_idle_pct = 24; rcv_idle_pct = 51; end
                1: begin snd_idle_pct = 51; rcv_idle_pct = 24; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // long receiver hold-off while items keep coming
                if (ph == 1 && k == 20) hold_toggle = ~hold_toggle;
                if ($urandom_range(2) == 0)
                    load_point(IDX_W'($urandom_range(MAX_POINTS - 1)), pick_coord(),
                               pick_coord());
                else
                    eval_at(pick_param());
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (sb.pending.size() != 0) begin
            $display("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("covered %0d point loads and %0d evaluations over %0d point counts",
                 load_count, eval_count, NUM_PHASES + 2);
        $display("%0d results compared, %0d mismatches", sb.matched, sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
